// ----- hdl/pt6k_pkg.sv -----
package pt6k_pkg;

    // Fixed constants of the 6k +/- 1 trial division
    localparam int unsigned C_TWO         = 2;
    localparam int unsigned C_THREE       = 3;
    localparam int unsigned C_TRIAL_FIRST = 5;
    localparam int unsigned C_TRIAL_STEP  = 6;
    localparam int unsigned C_PAIR_GAP    = 2;

    // Command from the sequencer to the shared divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Status from the shared divider back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_sts;

endpackage

// ----- hdl/pt6k_div.sv -----
module pt6k_div #(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pt6k_pkg::t_div_ctl  i_ctl,
    input  logic [WIDTH-1:0]    i_dividend,
    input  logic [WIDTH-1:0]    i_divisor,
    output pt6k_pkg::t_div_sts  o_sts,
    output logic [WIDTH-1:0]    o_quotient
);
    import pt6k_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_div;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;
    logic             q_bit;

    // One restoring step: shift in the next dividend bit, try a subtract
    always_comb begin
        shifted = {r_rem, r_quo[WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        q_bit   = ~diff[WIDTH+1];
        n_rem   = q_bit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        n_quo   = {r_quo[WIDTH-2:0], q_bit};
    end

    // Load a new division or advance the running one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_quotient     = r_quo;

endmodule

// ----- hdl/primality_test_6k_trial_division.sv -----
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_number   (WIDTH bits, unsigned)
// result    out        o_valid / i_stall    o_is_prime (1 bit)
//
// Each remainder is computed on the one shared bit-serial divider.
// Values below 4 and even values need no division, multiples of 3 need one;
// others need up to 2 + 2*P divisions, P pairs of 6k-1/6k+1 tried
// (P up to about sqrt(value)/6), the last remainder only ending the loop.
// Reset is synchronous and active low; it clears the sequencer and result valid.
// A stalled result is held in the output register while the next item is tested.
module primality_test_6k_trial_division #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_number,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_is_prime
);
    import pt6k_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MOD3   = 5'b00010,
        S_DIV_LO = 5'b00100,
        S_DIV_HI = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_num, n_num;
    logic [WIDTH-1:0] r_d, n_d;
    logic             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic             r_is_prime;
    logic             out_load;

    t_div_ctl         div_ctl;
    t_div_sts         div_sts;
    logic [WIDTH-1:0] div_dividend;
    logic [WIDTH-1:0] div_divisor;
    logic [WIDTH-1:0] div_quo;

    pt6k_div #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    // Sequence the divisions: 3, then pairs d and d+2 with d = 5, 11, 17, ...
    always_comb begin
        n_state       = r_state;
        n_num         = r_num;
        n_d           = r_d;
        n_res         = r_res;
        out_load      = 1'b0;
        div_ctl.start = 1'b0;
        div_dividend  = r_num;
        div_divisor   = r_d + WIDTH'(C_PAIR_GAP);
        case (r_state)
            S_IDLE: begin
                div_dividend = i_number;
                div_divisor  = WIDTH'(C_THREE);
                if (i_valid) begin
                    n_num = i_number;
                    if (i_number < WIDTH'(C_TWO)) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else if (i_number == WIDTH'(C_TWO) ||
                                 i_number == WIDTH'(C_THREE)) begin
                        n_res   = 1'b1;
                        n_state = S_DONE;
                    end else if (!i_number[0]) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        div_ctl.start = 1'b1;
                        n_state       = S_MOD3;
                    end
                end
            end
            S_MOD3: begin
                div_divisor = WIDTH'(C_TRIAL_FIRST);
                if (div_sts.done) begin
                    if (div_sts.rem_zero) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_d           = WIDTH'(C_TRIAL_FIRST);
                        div_ctl.start = 1'b1;
                        n_state       = S_DIV_LO;
                    end
                end
            end
            S_DIV_LO: begin
                div_divisor = r_d + WIDTH'(C_PAIR_GAP);
                if (div_sts.done) begin
                    // d > number / d means d * d > number: no divisor left
                    if (r_d > div_quo) begin
                        n_res   = 1'b1;
                        n_state = S_DONE;
                    end else if (div_sts.rem_zero) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        div_ctl.start = 1'b1;
                        n_state       = S_DIV_HI;
                    end
                end
            end
            S_DIV_HI: begin
                div_divisor = r_d + WIDTH'(C_TRIAL_STEP);
                if (div_sts.done) begin
                    if (div_sts.rem_zero) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_d           = r_d + WIDTH'(C_TRIAL_STEP);
                        div_ctl.start = 1'b1;
                        n_state       = S_DIV_LO;
                    end
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer on the output side
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_d   <= n_d;
        r_res <= n_res;
        if (out_load) begin
            r_is_prime <= r_res;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_is_prime;

endmodule

// ----- hdl/pt6k_chk.sv -----
module pt6k_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_is_prime
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_is_prime))
        else $error("result changed while stalled");

    // An input transfer makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after input transfer");

    // A new result appears only at the end of a test
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result raised while idle");

    // Going idle always leaves a result behind
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) |-> o_valid)
        else $error("block went idle without a result");

endmodule

bind primality_test_6k_trial_division pt6k_chk u_chk (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

// Predict and check the prime verdict of every number that enters the block
class prime_scoreboard;
    logic           verdict_q[$];
    longint unsigned number_q[$];
    int unsigned    n_numbers = 0;
    int unsigned    n_primes  = 0;
    int unsigned    n_errors  = 0;

    // Trial division by 2, 3 and then the 6k-1 / 6k+1 pairs
    function logic is_prime_6k(longint unsigned v);
        longint unsigned d;
        if (v < pt6k_pkg::C_TWO) return 1'b0;
        if (v == pt6k_pkg::C_TWO || v == pt6k_pkg::C_THREE) return 1'b1;
        if (v % pt6k_pkg::C_TWO == 0) return 1'b0;
        if (v % pt6k_pkg::C_THREE == 0) return 1'b0;
        // d <= v / d keeps the bound free of overflow
        for (d = pt6k_pkg::C_TRIAL_FIRST; d <= v / d; d += pt6k_pkg::C_TRIAL_STEP) begin
            if (v % d == 0) return 1'b0;
            if (v % (d + pt6k_pkg::C_PAIR_GAP) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Record the verdict owed for an accepted number
    function void note_number(longint unsigned v);
        logic verdict;
        verdict = is_prime_6k(v & 64'hFFFF_FFFF);
        verdict_q.push_back(verdict);
        number_q.push_back(v);
        n_numbers++;
        if (verdict) n_primes++;
    endfunction

    // Compare a delivered verdict with the oldest one owed
    function void check_verdict(logic actual);
        logic            want;
        longint unsigned v;
        if (verdict_q.size() == 0) begin
            $error("o_is_prime: no result expected, actual %0b", actual);
            n_errors++;
            return;
        end
        want = verdict_q.pop_front();
        v    = number_q.pop_front();
        if (actual !== want) begin
            $error("o_is_prime mismatch for number %0d: expected %0b, actual %0b",
                   v, want, actual);
            n_errors++;
        end
    endfunction

    function int unsigned pending();
        return verdict_q.size();
    endfunction
endclass

module testbench;
    localparam int WIDTH = 32;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic [WIDTH-1:0] i_number   = '0;
    logic             i_stall    = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic             o_is_prime;

    int unsigned      src_idle_pct  = 0;
    int unsigned      rcv_stall_pct = 0;
    int unsigned      rcv_hold_left = 0;

    prime_scoreboard  sb;

    primality_test_6k_trial_division #(
        .WIDTH(WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_prime (o_is_prime)
    );

    always #4 i_clk = ~i_clk;

    // Stall the result channel: long hold-off first, else at random
    initial begin
        forever begin
            @(negedge i_clk);
            if (rcv_hold_left != 0) begin
                i_stall <= 1'b1;
                rcv_hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
            end
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_verdict(o_is_prime);
    end

    // Offer one number, with random idle cycles ahead of it, until it transfers
    task automatic send_number(input logic [WIDTH-1:0] v);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid  <= 1'b0;
            i_number <= $urandom;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= v;
        do @(posedge i_clk); while (o_stall);
        sb.note_number(v);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every verdict owed has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // Mostly cheap numbers; full-width ones carry a small factor to bound run time
    function automatic logic [WIDTH-1:0] random_number();
        int unsigned      sel;
        int unsigned      p;
        logic [WIDTH-1:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            v = $urandom_range(0, 1000);
        end else if (sel < 55) begin
            v = $urandom_range(0, 65535);
        end else if (sel < 70) begin
            v = $urandom;
            if ($urandom_range(0, 1)) v[0] = 1'b0;
            else v = v - v % 3;
        end else if (sel < 90) begin
            p = 6 * $urandom_range(1, 16) - 1 + 2 * $urandom_range(0, 1);
            v = ($urandom % (32'hFFFF_FFFF / p)) * p;
        end else begin
            v = $urandom_range(0, 20'hF_FFFF);
        end
        return v;
    endfunction

    task automatic run_random(input int n, input int unsigned src_pct,
                              input int unsigned rcv_pct);
        src_idle_pct  = src_pct;
        rcv_stall_pct = rcv_pct;
        repeat (n) send_number(random_number());
        drain_results();
    endtask

    // Main sequence
    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Corner values: tiny, multiples of three, squares at the loop bound, extremes
        send_number(32'd0);     send_number(32'd1);    send_number(32'd2);
        send_number(32'd3);     send_number(32'd4);    send_number(32'd5);
        send_number(32'd7);     send_number(32'd9);    send_number(32'd15);
        send_number(32'd21);    send_number(32'd25);   send_number(32'd35);
        send_number(32'd49);    send_number(32'd121);  send_number(32'd143);
        send_number(32'd169);   send_number(32'd289);  send_number(32'd63001);
        send_number(32'd65521); send_number(32'd1048573);
        send_number(32'hFFFF_FFFF); send_number(32'hFFFF_FFFE);
        send_number(32'h8000_0001); send_number(32'd4294967291);
        drain_results();

        run_random(17, 0, 0);
        run_random(17, 58, 0);
        run_random(17, 0, 58);

        // Hold the result channel while numbers keep coming, so the block backs up
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        @(posedge i_clk);
        rcv_hold_left = 1000;
        @(negedge i_clk);
        repeat (8) send_number($urandom_range(0, 200));
        drain_results();

        run_random(17, 21, 21);

        // Watch for stray results after the last one
        repeat (200) @(posedge i_clk);
        $display("Checked %0d numbers (%0d prime): corner values, the largest 32-bit prime,",
                 sb.n_numbers, sb.n_primes);
        $display("random values of all widths under free flow, gaps, stalls and a long hold-off");
        if (sb.n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #48_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- primality_test_6k_trial_division.f -----
hdl/pt6k_pkg.sv
hdl/pt6k_div.sv
hdl/primality_test_6k_trial_division.sv
hdl/pt6k_chk.sv
tb/sv/testbench.sv
